// ===== rtl/ffsa_pkg.sv =====
// Package for the first-fit segment allocator: sizes, codes and state type.
// No dependencies.
`timescale 1ns / 1ps
package ffsa_pkg;
  localparam int MAX_SEGMENTS = 16;
  localparam int POOLS = 8;
  localparam int SEG_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int POOL_W = 3;
  localparam int ADDR_W = 25;
  localparam int LEN_W = 26;
  localparam int MEM_W = POOL_W + SEG_W;
  localparam logic [LEN_W-1:0] SIZE_LIMIT = 26'd33554432;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  // spare code, served as a query
  localparam logic [1:0] ACT_QUERY_ALT = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [25:0] SIZE_RESET [8] = '{26'd65536, 26'd393216, 26'd262144,
    26'd4194304, 26'd8000, 26'd0, 26'd0, 26'd33554432};

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_DECIDE, S_FIT_RD, S_FIT, S_INS_RD, S_INS_WR,
    S_FREE_RD, S_FREE, S_DEL_RD, S_DEL_WR, S_OUT
  } state_t;
endpackage

// ===== rtl/first_fit_segment_allocator_top.sv =====
// First-fit segment allocator top level: sequencer, segment memory, config.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps
// Usage: a request word enters on in_ (action, pool, length, free start);
// one result word leaves on out_ per request. Config writes on cfg_ set
// pool sizes; the user must make them only while the block is idle, since
// the block itself does not enforce it. One request is handled at a time.
// A scan of the pool's gaps reads the segments one by one from the shared
// segment memory, in S_SCAN_RD and S_SCAN. A query or a refused allocate
// ends after this scan; an allocate that places a segment adds a second
// walk and the insert shift, and a free adds the search for its entry and
// the delete shift. One shared compare/subtract unit computes every gap
// span.
// Reset clears segment counts (all pools empty) and restores pool sizes;
// the memory needs no clearing. A finished result is held in the output
// register until taken; in_tready stays low until the result is taken and
// the next request can be accepted at the following edge.
module first_fit_segment_allocator_top
  import ffsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], pool[4:2], request_length[30:5], free_start[55:31]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // granted_start[24:0], granted_length[50:25], largest_gap[76:51], status[78:77]
  output logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);
  state_t state_r, state_nxt;
  logic [LEN_W-1:0] size_r [POOLS];
  logic [CNT_W-1:0] count_r [POOLS];
  logic [ADDR_W-1:0] mem_start [POOLS*MAX_SEGMENTS];
  logic [LEN_W-1:0] mem_len [POOLS*MAX_SEGMENTS];

  logic [1:0] act_r;
  logic [POOL_W-1:0] pool_r;
  logic [LEN_W-1:0] req_r;
  logic [ADDR_W-1:0] fs_r;
  logic [CNT_W-1:0] g_r, g_nxt;          // gap or entry index
  logic [CNT_W-1:0] k_r, k_nxt;          // shift index
  logic [LEN_W-1:0] begin_r, begin_nxt;  // begin of current gap
  logic [LEN_W-1:0] best_r, best_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [ADDR_W-1:0] rd_start_r;
  logic [LEN_W-1:0] rd_len_r;
  logic [79:0] out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic rd_en;
  logic [SEG_W-1:0] rd_idx;
  logic wr_en;
  logic [SEG_W-1:0] wr_idx;
  logic [ADDR_W-1:0] wr_start;
  logic [LEN_W-1:0] wr_len;
  logic cnt_we;
  logic [CNT_W-1:0] cnt_wval;

  logic [CNT_W-1:0] cnt;
  logic [LEN_W-1:0] lim;
  logic [LEN_W-1:0] gap_end;
  logic [LEN_W-1:0] span;
  logic [LEN_W-1:0] seg_end;

  assign cnt = count_r[pool_r];
  assign lim = (size_r[pool_r] > SIZE_LIMIT) ? SIZE_LIMIT : size_r[pool_r];
  // shared unit: span of the current gap
  assign gap_end = (g_r < cnt) ? {1'b0, rd_start_r} : lim;
  assign span = (gap_end > begin_r) ? gap_end - begin_r : '0;
  // segments end within SIZE_LIMIT, so the sum fits
  assign seg_end = {1'b0, rd_start_r} + rd_len_r;

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_r;

  // registers and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < POOLS; i++) begin
        size_r[i] <= SIZE_RESET[i];
        count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) size_r[cfg_index] <= cfg_data;
      if (cnt_we) count_r[pool_r] <= cnt_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r <= in_tdata[1:0];
      pool_r <= in_tdata[4:2];
      req_r <= in_tdata[30:5];
      fs_r <= in_tdata[55:31];
    end
    g_r <= g_nxt;
    k_r <= k_nxt;
    begin_r <= begin_nxt;
    best_r <= best_nxt;
    len_r <= len_nxt;
    out_r <= out_nxt;
  end

  // segment memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start_r <= mem_start[{pool_r, rd_idx}];
      rd_len_r <= mem_len[{pool_r, rd_idx}];
    end
    if (wr_en) begin
      mem_start[{pool_r, wr_idx}] <= wr_start;
      mem_len[{pool_r, wr_idx}] <= wr_len;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    g_nxt = g_r;
    k_nxt = k_r;
    begin_nxt = begin_r;
    best_nxt = best_r;
    len_nxt = len_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    rd_en = 1'b0;
    rd_idx = g_r[SEG_W-1:0];
    wr_en = 1'b0;
    wr_idx = k_r[SEG_W-1:0];
    wr_start = rd_start_r;
    wr_len = rd_len_r;
    cnt_we = 1'b0;
    cnt_wval = cnt;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          g_nxt = '0;
          begin_nxt = '0;
          best_nxt = '0;
          state_nxt = S_SCAN_RD;
        end
      end
      // read segment g to close gap g
      S_SCAN_RD: begin
        rd_en = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (span > best_r) best_nxt = span;
        if (g_r < cnt) begin
          begin_nxt = seg_end;
          g_nxt = g_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        out_nxt = {1'b0, ST_OK, best_r, {LEN_W{1'b0}}, {ADDR_W{1'b0}}};
        g_nxt = '0;
        begin_nxt = '0;
        len_nxt = (req_r > best_r) ? best_r : req_r;
        state_nxt = S_OUT;
        if (act_r == ACT_ALLOC) begin
          if (cnt >= CNT_W'(MAX_SEGMENTS)) out_nxt[78:77] = ST_FULL;
          else if (((req_r > best_r) ? best_r : req_r) == '0)
            out_nxt[78:77] = ST_NO_SPACE;
          else state_nxt = S_FIT_RD;
        end else if (act_r == ACT_FREE) begin
          out_nxt[78:77] = ST_NOT_FOUND;
          state_nxt = S_FREE_RD;
        end
      end
      // second walk: first gap that fits
      S_FIT_RD: begin
        rd_en = 1'b1;
        state_nxt = S_FIT;
      end
      S_FIT: begin
        if (span >= len_r) begin
          out_nxt[24:0] = begin_r[ADDR_W-1:0];
          out_nxt[50:25] = len_r;
          out_nxt[78:77] = ST_OK;
          k_nxt = cnt;
          state_nxt = S_INS_RD;
        end else begin
          begin_nxt = seg_end;
          g_nxt = g_r + 1'b1;
          state_nxt = S_FIT_RD;
        end
      end
      // shift entries up from the top, then write the new one
      S_INS_RD: begin
        if (k_r > g_r) begin
          rd_en = 1'b1;
          rd_idx = SEG_W'(k_r - 1'b1);
          state_nxt = S_INS_WR;
        end else begin
          wr_en = 1'b1;
          wr_start = begin_r[ADDR_W-1:0];
          wr_len = len_r;
          cnt_we = 1'b1;
          cnt_wval = cnt + 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_INS_WR: begin
        wr_en = 1'b1;
        k_nxt = k_r - 1'b1;
        state_nxt = S_INS_RD;
      end
      // search the entry to free
      S_FREE_RD: begin
        if (g_r < cnt) begin
          rd_en = 1'b1;
          state_nxt = S_FREE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FREE: begin
        if (rd_start_r == fs_r) begin
          out_nxt[78:77] = ST_OK;
          k_nxt = g_r;
          state_nxt = S_DEL_RD;
        end else begin
          g_nxt = g_r + 1'b1;
          state_nxt = S_FREE_RD;
        end
      end
      // shift entries down over the freed one
      S_DEL_RD: begin
        if (k_r + 1'b1 < cnt) begin
          rd_en = 1'b1;
          rd_idx = SEG_W'(k_r + 1'b1);
          state_nxt = S_DEL_WR;
        end else begin
          cnt_we = 1'b1;
          cnt_wval = cnt - 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_DEL_WR: begin
        wr_en = 1'b1;
        k_nxt = k_r + 1'b1;
        state_nxt = S_DEL_RD;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== test/ffsa_checker.sv =====
// Checker for the first-fit segment allocator: predicts each result word from
// the accepted request words and config writes, and compares field by field.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps
module ffsa_checker
  import ffsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // action[1:0], pool[4:2], request_length[30:5], free_start[55:31]
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // granted_start[24:0], granted_length[50:25], largest_gap[76:51], status[78:77]
  input  logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  gap;
    logic [1:0]        status;
  } grant_t;

  grant_t      grant_q[$];
  logic [25:0] size_copy [POOLS];
  int unsigned seg_lo [POOLS][MAX_SEGMENTS];
  int unsigned seg_len [POOLS][MAX_SEGMENTS];
  int unsigned seg_cnt [POOLS];

  function automatic int unsigned pool_cap(int p);
    int unsigned s;
    s = size_copy[p];
    return (s > SIZE_LIMIT) ? SIZE_LIMIT : s;
  endfunction

  function automatic int unsigned gap_lo(int p, int g);
    if (g == 0) return 0;
    return seg_lo[p][g-1] + seg_len[p][g-1];
  endfunction

  function automatic int unsigned gap_hi(int p, int g);
    if (g < seg_cnt[p]) return seg_lo[p][g];
    return pool_cap(p);
  endfunction

  // Shrunk pools can leave a gap end below its begin: count it as empty
  function automatic int unsigned span_of(int unsigned a, int unsigned b);
    return (b > a) ? b - a : 0;
  endfunction

  function automatic int unsigned widest_gap(int p);
    int unsigned best;
    best = 0;
    for (int g = 0; g <= seg_cnt[p]; g++)
      if (span_of(gap_lo(p, g), gap_hi(p, g)) > best) best = span_of(gap_lo(p, g), gap_hi(p, g));
    return best;
  endfunction

  // Apply one request to the segment tables and return the result it gives
  function automatic grant_t serve_request(logic [55:0] w);
    grant_t      r;
    logic [1:0]  act;
    int          p;
    int unsigned req, fs, len, cnt, b, widest;
    bit          done;
    act = w[1:0];
    p = w[4:2];
    req = w[30:5];
    fs = w[55:31];
    widest = widest_gap(p);
    r.start = '0;
    r.length = '0;
    r.gap = LEN_W'(widest);
    r.status = ST_OK;
    done = 0;
    cnt = seg_cnt[p];
    if (act == ACT_ALLOC) begin
      if (cnt >= MAX_SEGMENTS) begin
        r.status = ST_FULL;
      end else begin
        len = (req > widest) ? widest : req;
        r.status = ST_NO_SPACE;
        if (len != 0) begin
          for (int g = 0; g <= cnt && !done; g++) begin
            b = gap_lo(p, g);
            if (span_of(b, gap_hi(p, g)) >= len) begin
              done = 1;
              for (int k = cnt; k > g; k--) begin
                seg_lo[p][k] = seg_lo[p][k-1];
                seg_len[p][k] = seg_len[p][k-1];
              end
              seg_lo[p][g] = b;
              seg_len[p][g] = len;
              seg_cnt[p] = cnt + 1;
              r.start = ADDR_W'(b);
              r.length = LEN_W'(len);
              r.status = ST_OK;
            end
          end
        end
      end
    end else if (act == ACT_FREE) begin
      r.status = ST_NOT_FOUND;
      for (int i = 0; i < cnt && !done; i++) begin
        if (seg_lo[p][i] == fs) begin
          done = 1;
          for (int k = i; k + 1 < cnt; k++) begin
            seg_lo[p][k] = seg_lo[p][k+1];
            seg_len[p][k] = seg_len[p][k+1];
          end
          seg_cnt[p] = cnt - 1;
          r.status = ST_OK;
        end
      end
    end
    return r;
  endfunction

  // Track config, predict on each request word, compare each result word
  always @(posedge clk) begin
    grant_t exp_r;
    if (!rst_n) begin
      for (int p = 0; p < POOLS; p++) begin
        size_copy[p] = SIZE_RESET[p];
        seg_cnt[p] = 0;
      end
      grant_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (cfg_we) size_copy[cfg_index] = cfg_data;
      if (out_tvalid && out_tready) begin
        if (grant_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          exp_r = grant_q.pop_front();
          if (out_tdata[24:0] !== exp_r.start) begin
            $error("granted_start: expected %0d, got %0d", exp_r.start, out_tdata[24:0]);
            fail_count++;
          end
          if (out_tdata[50:25] !== exp_r.length) begin
            $error("granted_length: expected %0d, got %0d", exp_r.length, out_tdata[50:25]);
            fail_count++;
          end
          if (out_tdata[76:51] !== exp_r.gap) begin
            $error("largest_gap: expected %0d, got %0d", exp_r.gap, out_tdata[76:51]);
            fail_count++;
          end
          if (out_tdata[78:77] !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_tdata[78:77]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) grant_q.push_back(serve_request(in_tdata));
      pending <= grant_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the allocator testbench: clock, reset, request stimulus, config
// phases and the verdict. Depends on ffsa_pkg, ffsa_checker and the block.
`timescale 1ns / 1ps
module testbench;
  import ffsa_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [25:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          cycles = 0;
  logic [25:0] pool_sizes [POOLS];
  int unsigned live_starts [POOLS][$];
  logic [4:0]  sent_q[$];

  first_fit_segment_allocator_top u_dut (.*);

  ffsa_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_idle_pct);

  // Time out a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Remember granted starts so that most frees hit a live segment
  always @(posedge clk) begin
    logic [4:0] tag;
    if (rst_n && out_tvalid && out_tready && sent_q.size() != 0) begin
      tag = sent_q.pop_front();
      if (tag[1:0] == ACT_ALLOC && out_tdata[78:77] == ST_OK)
        live_starts[tag[4:2]].push_back(out_tdata[24:0]);
    end
    if (rst_n && in_tvalid && in_tready) sent_q.push_back(in_tdata[4:0]);
  end

  task automatic send_word(logic [1:0] act, int p, int unsigned req, int unsigned fs);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {fs[24:0], req[25:0], p[2:0], act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and hold until every result word has come back
  task automatic drain();
    in_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sizes(logic [25:0] v [POOLS]);
    for (int i = 0; i < POOLS; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      pool_sizes[i] = v[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_word();
    int          p, r, idx;
    int unsigned cap, req, fs;
    logic [1:0]  act;
    p = $urandom_range(POOLS - 1);
    r = $urandom_range(99);
    cap = (pool_sizes[p] > SIZE_LIMIT) ? SIZE_LIMIT : pool_sizes[p];
    act = (r < 45) ? ACT_ALLOC : (r < 80) ? ACT_FREE : (r < 97) ? ACT_QUERY : ACT_QUERY_ALT;
    r = $urandom_range(99);
    if (r < 8 || cap == 0) req = (r < 4) ? 0 : $urandom_range(SIZE_LIMIT);
    else if (r < 16) req = $urandom_range(SIZE_LIMIT);
    else if (r < 75) req = $urandom_range(1, (cap / 6 > 1) ? cap / 6 : 1);
    else req = $urandom_range(1, cap);
    fs = $urandom & 32'h1FFFFFF;
    if (act == ACT_FREE && live_starts[p].size() != 0 && $urandom_range(9) < 8) begin
      idx = $urandom_range(live_starts[p].size() - 1);
      fs = live_starts[p][idx];
      live_starts[p].delete(idx);
    end
    send_word(act, p, req, fs);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) drain();
      random_word();
    end
    drain();
  endtask

  initial begin
    logic [25:0] sizes_a [POOLS];
    logic [25:0] sizes_b [POOLS];
    sizes_a = '{26'd0, 26'd1, 26'd33554432, 26'h3FFFFFF, 26'd1000, 26'd5000, 26'd200, 26'd64};
    sizes_b = '{26'd500, 26'd100000, 26'd12, 26'd33554432, 26'd7, 26'd3000, 26'd1, 26'd0};
    for (int i = 0; i < POOLS; i++) pool_sizes[i] = SIZE_RESET[i];
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, each action, table full, free miss, front gap
    tx_idle_pct = 14;
    rx_idle_pct = 66;
    send_word(ACT_QUERY, 0, 0, 0);
    send_word(ACT_QUERY_ALT, 7, 0, 0);
    send_word(ACT_ALLOC, 0, 0, 0);
    send_word(ACT_ALLOC, 0, SIZE_LIMIT, 0);
    send_word(ACT_FREE, 0, 0, 0);
    send_word(ACT_FREE, 0, 0, 0);
    send_word(ACT_FREE, 1, 0, 32'h1FFFFFF);
    send_word(ACT_ALLOC, 5, 10, 0);
    for (int i = 0; i < MAX_SEGMENTS + 1; i++) send_word(ACT_ALLOC, 4, 400, 0);
    send_word(ACT_FREE, 4, 0, 0);
    send_word(ACT_ALLOC, 4, 1, 0);
    drain();
    for (int i = 0; i < POOLS; i++) live_starts[i].delete();

    random_phase(360);
    write_sizes(sizes_a);
    tx_idle_pct = 66;
    rx_idle_pct = 14;
    random_phase(380);
    write_sizes(sizes_b);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(380);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ffsa_pkg.sv
rtl/first_fit_segment_allocator_top.sv
test/ffsa_checker.sv
test/testbench.sv
